### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the link supervisor modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### hdl/lsrw_pkg.sv
// ----------------------------------------------------------------------------
// Link supervisor package
// Types, codes and constants shared by the link supervisor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsrw_pkg;

    // Link state codes.
    typedef enum logic [1:0] {
        ST_DISC  = 2'd0,
        ST_CONN  = 2'd1,
        ST_RETRY = 2'd2,
        ST_AP    = 2'd3
    } link_state_t;

    // Command codes.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_POLL  = 2'd1,
        OP_FORCE = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RECONNECT_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_REBOOT_TIMEOUT     = 2'd1;
    localparam logic [1:0] CFG_REBOOT_ENABLE      = 2'd2;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TIMEOUT_W = 17;
    localparam int unsigned LIMIT_W   = 33;

    localparam logic [15:0]       MS_PER_MIN        = 16'd60000;
    localparam logic [TIME_W-1:0] RECONNECT_DEFAULT = 32'd10000;

    // Settings seen by the step logic.
    typedef struct packed {
        logic [TIME_W-1:0]  reconnect_interval;
        logic [LIMIT_W-1:0] reboot_limit;
        logic               reboot_armed;
    } cfg_t;

    // One command item.
    typedef struct packed {
        op_t               op;
        logic              ap_mode;
        logic              link_up;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    // One result item.
    typedef struct packed {
        link_state_t       link_state;
        logic              connected_event;
        logic              disconnected_event;
        logic              ap_event;
        logic              reconnect_request;
        logic              reboot_request;
        logic [TIME_W-1:0] since_good_ms;
    } result_t;

endpackage

### hdl/link_supervisor_with_reboot_watchdog.sv
// ----------------------------------------------------------------------------
// Link supervisor with reboot watchdog
// Usage:
//   Commands arrive on the input channel (in_valid / in_stall) with fields
//   operation, ap_mode, link_up and now_ms. Each accepted command yields one
//   result on the output channel (out_valid / out_stall): the link state
//   after the command, one-shot connected, disconnected and access point
//   events, a reconnect request, a reboot request and the milliseconds
//   since the last good link.
//   Settings are written on the cfg channel (cfg_valid / cfg_ready, index
//   and data); cfg_ready is always high. Write settings only while idle.
//   Each command passes through the input register, the core logic and the
//   result register; one command per cycle is sustained while the receiver
//   does not stall, with the core updating its state once per command.
//   While the receiver stalls, the finished result holds in the output
//   register and one more command is taken into the input register; after
//   that in_stall rises.
//   Reset clears the link state to disconnected, clears start and both
//   timestamps, and loads the default reconnect interval of 10000 ms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module link_supervisor_with_reboot_watchdog
    import lsrw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic        ap_mode,
    input  logic        link_up,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  link_state,
    output logic        connected_event,
    output logic        disconnected_event,
    output logic        ap_event,
    output logic        reconnect_request,
    output logic        reboot_request,
    output logic [31:0] since_good_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign cfg_ready = 1'b1;

    lsrw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake control between the input and output registers.
    assign advance  = item_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Input register captures the transfer.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op      <= op_t'(operation);
            item_reg.ap_mode <= ap_mode;
            item_reg.link_up <= link_up;
            item_reg.now_ms  <= now_ms;
        end
    end

    lsrw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign out_valid          = out_valid_reg;
    assign link_state         = result_reg.link_state;
    assign connected_event    = result_reg.connected_event;
    assign disconnected_event = result_reg.disconnected_event;
    assign ap_event           = result_reg.ap_event;
    assign reconnect_request  = result_reg.reconnect_request;
    assign reboot_request     = result_reg.reboot_request;
    assign since_good_ms      = result_reg.since_good_ms;

    // At most one transition event per result.
    `ASSERT_IMPLY(a_one_event, clk, rst_n, out_valid_reg, $onehot0({connected_event, disconnected_event, ap_event}))
    // A connected result never carries a reconnect request.
    `ASSERT_IMPLY(a_conn_no_retry, clk, rst_n, out_valid_reg && link_state == ST_CONN, !reconnect_request)
    // An access point result never carries a reboot request.
    `ASSERT_IMPLY(a_ap_no_boot, clk, rst_n, out_valid_reg && link_state == ST_AP, !reboot_request)

endmodule

### hdl/lsrw_cfg.sv
// ----------------------------------------------------------------------------
// Link supervisor configuration
// Holds the writable settings and precomputes the reboot threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsrw_cfg
    import lsrw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    logic [TIME_W-1:0]    interval_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 enable_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // Register writes; an unknown index is dropped. The threshold in
    // milliseconds is loaded together with the timeout, so it is valid
    // from the same edge on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= RECONNECT_DEFAULT;
            timeout_reg  <= '0;
            enable_reg   <= 1'b0;
            limit_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RECONNECT_INTERVAL: interval_reg <= cfg_data;
                CFG_REBOOT_TIMEOUT:
                begin
                    timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    limit_reg   <= LIMIT_W'(cfg_data[TIMEOUT_W-1:0]) *
                                   LIMIT_W'(MS_PER_MIN);
                end
                CFG_REBOOT_ENABLE:      enable_reg   <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign cfg.reconnect_interval = interval_reg;
    assign cfg.reboot_limit       = limit_reg;
    assign cfg.reboot_armed       = enable_reg && (timeout_reg != '0);

endmodule

### hdl/lsrw_core.sv
// ----------------------------------------------------------------------------
// Link supervisor core
// Link state machine, timestamps and the per-item result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lsrw_core
    import lsrw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    link_state_t       mode_reg, mode_next;
    logic              started_reg, started_next;
    logic [TIME_W-1:0] last_good_reg, last_good_next;
    logic [TIME_W-1:0] last_retry_reg, last_retry_next;

    logic              poll_live;
    logic              retry_due;
    logic [TIME_W-1:0] gap;

    assign poll_live = (item.op == OP_POLL) && started_reg;
    assign retry_due = (item.now_ms - last_retry_reg) >= cfg.reconnect_interval;

    // Next state and timestamps.
    always_comb
    begin
        mode_next       = mode_reg;
        started_next    = started_reg;
        last_good_next  = last_good_reg;
        last_retry_next = last_retry_reg;
        case (item.op)
            OP_START:
            begin
                started_next    = 1'b1;
                last_good_next  = item.now_ms;
                last_retry_next = '0;
                if (item.ap_mode)
                    mode_next = ST_AP;
                else if (item.link_up)
                    mode_next = ST_CONN;
                else
                    mode_next = ST_DISC;
            end
            OP_POLL:
            begin
                if (started_reg)
                begin
                    if (item.ap_mode)
                        mode_next = ST_AP;
                    else if (item.link_up)
                    begin
                        mode_next      = ST_CONN;
                        last_good_next = item.now_ms;
                    end
                    else if (retry_due)
                    begin
                        mode_next       = ST_RETRY;
                        last_retry_next = item.now_ms;
                    end
                    else if (mode_reg == ST_CONN)
                        mode_next = ST_DISC;
                end
            end
            OP_FORCE:
                last_retry_next = '0;
            OP_RESET:
            begin
                mode_next       = ST_DISC;
                last_good_next  = item.now_ms;
                last_retry_next = '0;
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    assign gap = item.now_ms - last_good_next;

    // Result fields: events and requests only on a poll after start.
    always_comb
    begin
        result.link_state         = mode_next;
        result.since_good_ms      = gap;
        result.ap_event           = poll_live && item.ap_mode && (mode_reg != ST_AP);
        result.connected_event    = poll_live && !item.ap_mode && item.link_up &&
                                    (mode_reg != ST_CONN);
        result.disconnected_event = poll_live && !item.ap_mode && !item.link_up &&
                                    (mode_reg == ST_CONN);
        result.reconnect_request  = poll_live && !item.ap_mode && !item.link_up &&
                                    retry_due;
        result.reboot_request     = poll_live && cfg.reboot_armed &&
                                    (mode_next != ST_AP) &&
                                    ({1'b0, gap} >= cfg.reboot_limit);
    end

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_DISC;
            started_reg    <= 1'b0;
            last_good_reg  <= '0;
            last_retry_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            started_reg    <= started_next;
            last_good_reg  <= last_good_next;
            last_retry_reg <= last_retry_next;
        end
    end

    // A connected event leaves the machine connected.
    `ASSERT_NEXT(a_conn_state, clk, rst_n, fire && result.connected_event, mode_reg == ST_CONN)
    // A reconnect request stamps the retry time with the poll time.
    `ASSERT_NEXT(a_retry_stamp, clk, rst_n, fire && result.reconnect_request, last_retry_reg == $past(item.now_ms))
    // A poll before start leaves the link state alone.
    `ASSERT_NEXT(a_idle_poll, clk, rst_n, fire && !started_reg && item.op == OP_POLL, $stable(mode_reg))

endmodule
